/* design/snpdec_pkg.sv */
// Types and constants shared by the raw block decompressor and its checker.
// No dependencies.
package snpdec_pkg;

  // Closing status of a frame.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TRUNC_VARINT = 3'd1,
    ST_VARINT_OVF   = 3'd2,
    ST_DECL_BIG     = 3'd3,
    ST_TRUNC_ELEM   = 3'd4,
    ST_LIT_OVER     = 3'd5,
    ST_BAD_COPY     = 3'd6,
    ST_LEN_MISMATCH = 3'd7
  } status_e;

  // Decoder state, one-hot.
  typedef enum logic [6:0] {
    S_VARINT  = 7'b0000001,
    S_TAG     = 7'b0000010,
    S_LITLEN  = 7'b0000100,
    S_LITDATA = 7'b0001000,
    S_COPYOFF = 7'b0010000,
    S_COPYCHK = 7'b0100000,
    S_COPYRUN = 7'b1000000
  } state_e;

  // Tag kinds (low two bits of a tag byte).
  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_COPY1 = 2'd1;
  localparam logic [1:0] KIND_COPY2 = 2'd2;
  localparam logic [1:0] KIND_COPY4 = 2'd3;

  localparam int unsigned CFG_W    = 17;
  localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

  localparam int unsigned EXT_W    = 32;  // assembled offset or literal length
  localparam int unsigned LEN_W    = 7;   // copy length, up to 64
  localparam int unsigned VIDX_W   = 4;   // varint byte index
  localparam int unsigned VSH_W    = 7;   // varint bit position
  localparam logic [VIDX_W-1:0] VIDX_LAST = 4'd9;
  localparam logic [5:0] SHORT_LIT_MAX = 6'd59;
  localparam logic [5:0] LONG_LIT_BIAS = 6'd59;
  localparam logic [LEN_W-1:0] COPY1_BASE = 7'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       frame_end;
    status_e    status;
  } out_t;

  // Number of bytes that follow a tag before its element can start.
  function automatic logic [2:0] extra_total(input logic [1:0] kind, input logic [5:0] info);
    logic [5:0] d;
    logic [2:0] r;
    d = info - LONG_LIT_BIAS;
    case (kind)
      KIND_LIT:   r = (info > SHORT_LIT_MAX) ? d[2:0] : 3'd1;
      KIND_COPY1: r = 3'd1;
      KIND_COPY2: r = 3'd2;
      KIND_COPY4: r = 3'd4;
      default:    r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

/* design/snpdec_ram.sv */
// Generic single-clock RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents.
module snpdec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/snappy_raw_block_decompressor_core.sv */
// Raw snappy block decompressor: one compressed frame in, decoded bytes out.
// Depends on snpdec_pkg and snpdec_ram (history store).
//
//   channel | direction | payload             | handshake
//   --------+-----------+---------------------+-------------------------
//   in      | in        | snpdec_pkg::in_t    | in_valid_i / in_ready_o
//   out     | out       | snpdec_pkg::out_t   | out_valid_o / out_ready_i
//   cfg     | in        | max_output_length   | cfg_valid_i / cfg_ready_o
//
// Header, tag, length and literal bytes are taken one per cycle while the output
// register can take a result. A copy checks its offset in S_COPYCHK and, while
// that holds, replays one byte per cycle, paced by the single read port of the
// history RAM. Reset is asynchronous; the history RAM needs no clearing pass.
// A stalled output holds the input off; a stalled copy re-reads its source.
module snappy_raw_block_decompressor_core #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  snpdec_pkg::in_t                in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output snpdec_pkg::out_t               out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [snpdec_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned AddrW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned ExtW   = snpdec_pkg::EXT_W;
  localparam int unsigned SumW   = ((CntW > ExtW) ? CntW : ExtW) + 1;
  localparam int unsigned ShW    = snpdec_pkg::VSH_W;
  localparam int unsigned LenW   = snpdec_pkg::LEN_W;
  localparam int unsigned LimRstInt =
      (HISTORY_DEPTH < int'(snpdec_pkg::CFG_RESET)) ? HISTORY_DEPTH
                                                    : int'(snpdec_pkg::CFG_RESET);
  localparam logic [CntW-1:0] LimRst  = CntW'(LimRstInt);
  localparam logic [ShW-1:0]  CntWAmt = ShW'(CntW);

  snpdec_pkg::state_e  state_q, state_d;
  snpdec_pkg::status_e err_q, err_d;
  logic                drop_q, drop_d;
  logic [CntW-1:0]     vval_q, vval_d;
  logic                vbig_q, vbig_d;
  logic [snpdec_pkg::VIDX_W-1:0] vidx_q, vidx_d;
  logic [CntW-1:0]     decl_q, decl_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     lim_q, lim_d;
  logic [1:0]          kind_q, kind_d;
  logic [5:0]          info_q, info_d;
  logic [2:0]          xleft_q, xleft_d;
  logic [1:0]          xidx_q, xidx_d;
  logic [ExtW-1:0]     extra_q, extra_d;
  logic [CntW-1:0]     litleft_q, litleft_d;
  logic                last_q, last_d;
  logic [AddrW-1:0]    rd_addr_q, rd_addr_d;
  logic [LenW-1:0]     cpleft_q, cpleft_d;
  logic                out_valid_q, out_valid_d;
  snpdec_pkg::out_t    out_q, out_d;
  logic                fwd_q, fwd_d;
  logic [7:0]          fwd_data_q;

  logic                out_free, in_state, in_fire;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata, hist_byte;

  logic [6:0]          chunk;
  logic [ShW-1:0]      sh_amt;
  logic [CntW+6:0]     sh;
  logic [CntW-1:0]     val_new;
  logic                big_new;
  logic [ExtW-1:0]     extra_new;
  logic [SumW-1:0]     lit_base, lit_len;
  logic                lit_over;
  logic [ExtW-1:0]     cp_off;
  logic [LenW-1:0]     cp_len;
  logic                cp_bad;
  logic [CntW-1:0]     cp_src;
  logic                emit_v, close_v;
  logic [7:0]          emit_b;
  snpdec_pkg::status_e close_st;

  function automatic snpdec_pkg::status_e end_status(
    input logic drop, input snpdec_pkg::status_e err, input snpdec_pkg::state_e st,
    input logic [CntW-1:0] cnt, input logic [CntW-1:0] decl);
    snpdec_pkg::status_e r;
    if (drop) begin
      r = err;
    end else begin
      case (st)
        snpdec_pkg::S_VARINT:  r = snpdec_pkg::ST_TRUNC_VARINT;
        snpdec_pkg::S_LITLEN:  r = snpdec_pkg::ST_TRUNC_ELEM;
        snpdec_pkg::S_COPYOFF: r = snpdec_pkg::ST_TRUNC_ELEM;
        snpdec_pkg::S_LITDATA: r = snpdec_pkg::ST_LIT_OVER;
        default: r = (cnt != decl) ? snpdec_pkg::ST_LEN_MISMATCH : snpdec_pkg::ST_OK;
      endcase
    end
    return r;
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_state   = (state_q == snpdec_pkg::S_VARINT) || (state_q == snpdec_pkg::S_TAG) ||
                      (state_q == snpdec_pkg::S_LITLEN) || (state_q == snpdec_pkg::S_LITDATA) ||
                      (state_q == snpdec_pkg::S_COPYOFF);
  assign in_ready_o  = in_state && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The RAM is read-first, so a byte written in the cycle its address is
  // read comes from the forwarding register instead.
  assign hist_byte = fwd_q ? fwd_data_q : ram_rdata;

  snpdec_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Varint, extra-byte assembly and the limit checks.
  always_comb begin
    chunk  = (vidx_q == snpdec_pkg::VIDX_LAST) ? {6'd0, in_i.in_byte[0]} : in_i.in_byte[6:0];
    sh_amt = (ShW'(vidx_q) << 3) - ShW'(vidx_q);
    sh     = {{CntW{1'b0}}, chunk} << sh_amt;
    val_new = vval_q | sh[CntW-1:0];
    big_new = vbig_q | ((sh_amt >= CntWAmt) ? (|chunk) : (|sh[CntW+6:CntW]));

    extra_new = extra_q | (ExtW'(in_i.in_byte) << {xidx_q, 3'b000});
    lit_base  = (state_q == snpdec_pkg::S_TAG) ? SumW'(in_i.in_byte[7:2]) : SumW'(extra_new);
    lit_len   = lit_base + SumW'(1);
    lit_over  = (SumW'(count_q) + lit_base) >= SumW'(lim_q);

    if (kind_q == snpdec_pkg::KIND_COPY1) begin
      cp_off = ExtW'({info_q[5:3], extra_q[7:0]});
      cp_len = LenW'(info_q[2:0]) + snpdec_pkg::COPY1_BASE;
    end else begin
      cp_off = extra_q;
      cp_len = LenW'(info_q) + LenW'(1);
    end
    cp_bad = (cp_off == '0) || (SumW'(cp_off) > SumW'(count_q)) ||
             ((SumW'(count_q) + SumW'(cp_len)) > SumW'(lim_q));
    cp_src = count_q - cp_off[CntW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    err_d     = err_q;
    drop_d    = drop_q;
    vval_d    = vval_q;
    vbig_d    = vbig_q;
    vidx_d    = vidx_q;
    decl_d    = decl_q;
    count_d   = count_q;
    kind_d    = kind_q;
    info_d    = info_q;
    xleft_d   = xleft_q;
    xidx_d    = xidx_q;
    extra_d   = extra_q;
    litleft_d = litleft_q;
    last_d    = last_q;
    rd_addr_d = rd_addr_q;
    cpleft_d  = cpleft_q;
    lim_d     = lim_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[AddrW-1:0];
    ram_wdata = in_i.in_byte;
    ram_raddr = rd_addr_q;
    emit_v    = 1'b0;
    emit_b    = in_i.in_byte;
    close_v   = 1'b0;
    close_st  = snpdec_pkg::ST_OK;

    if (cfg_valid_i) begin
      if (32'(cfg_data_i) > 32'(HISTORY_DEPTH)) begin
        lim_d = CntW'(HISTORY_DEPTH);
      end else begin
        lim_d = CntW'(cfg_data_i);
      end
    end

    if (in_fire) begin
      if (!drop_q) begin
        case (state_q)
          snpdec_pkg::S_VARINT: begin
            vval_d = val_new;
            vbig_d = big_new;
            if (!in_i.in_byte[7]) begin
              if (big_new || (val_new > lim_q)) begin
                drop_d = 1'b1;
                err_d  = snpdec_pkg::ST_DECL_BIG;
              end else begin
                decl_d  = val_new;
                state_d = snpdec_pkg::S_TAG;
              end
            end else if (vidx_q == snpdec_pkg::VIDX_LAST) begin
              drop_d = 1'b1;
              err_d  = snpdec_pkg::ST_VARINT_OVF;
            end else begin
              vidx_d = vidx_q + 1'b1;
            end
          end
          snpdec_pkg::S_TAG: begin
            kind_d  = in_i.in_byte[1:0];
            info_d  = in_i.in_byte[7:2];
            extra_d = '0;
            xidx_d  = '0;
            if ((in_i.in_byte[1:0] == snpdec_pkg::KIND_LIT) &&
                (in_i.in_byte[7:2] <= snpdec_pkg::SHORT_LIT_MAX)) begin
              if (lit_over) begin
                drop_d = 1'b1;
                err_d  = snpdec_pkg::ST_LIT_OVER;
              end else begin
                litleft_d = lit_len[CntW-1:0];
                state_d   = snpdec_pkg::S_LITDATA;
              end
            end else begin
              xleft_d = snpdec_pkg::extra_total(in_i.in_byte[1:0], in_i.in_byte[7:2]);
              state_d = (in_i.in_byte[1:0] == snpdec_pkg::KIND_LIT) ? snpdec_pkg::S_LITLEN
                                                                     : snpdec_pkg::S_COPYOFF;
            end
          end
          snpdec_pkg::S_LITLEN: begin
            extra_d = extra_new;
            xleft_d = xleft_q - 1'b1;
            xidx_d  = xidx_q + 1'b1;
            if (xleft_q == 3'd1) begin
              if (lit_over) begin
                drop_d = 1'b1;
                err_d  = snpdec_pkg::ST_LIT_OVER;
              end else begin
                litleft_d = lit_len[CntW-1:0];
                state_d   = snpdec_pkg::S_LITDATA;
              end
            end
          end
          snpdec_pkg::S_LITDATA: begin
            ram_we    = 1'b1;
            emit_v    = 1'b1;
            count_d   = count_q + 1'b1;
            litleft_d = litleft_q - 1'b1;
            if (litleft_q == CntW'(1)) begin
              state_d = snpdec_pkg::S_TAG;
            end
          end
          snpdec_pkg::S_COPYOFF: begin
            extra_d = extra_new;
            xleft_d = xleft_q - 1'b1;
            xidx_d  = xidx_q + 1'b1;
            if (xleft_q == 3'd1) begin
              state_d = snpdec_pkg::S_COPYCHK;
            end
          end
          default: begin
            state_d = snpdec_pkg::S_VARINT;
          end
        endcase
      end
      if (in_i.in_last) begin
        // A frame that ends on a copy's last offset byte closes after the copy.
        if (!drop_d && (state_d == snpdec_pkg::S_COPYCHK)) begin
          last_d = 1'b1;
        end else begin
          close_v = 1'b1;
        end
      end
    end

    case (state_q)
      snpdec_pkg::S_COPYCHK: begin
        if (cp_bad) begin
          if (!last_q) begin
            drop_d  = 1'b1;
            err_d   = snpdec_pkg::ST_BAD_COPY;
            state_d = snpdec_pkg::S_TAG;
          end else if (out_free) begin
            drop_d  = 1'b1;
            err_d   = snpdec_pkg::ST_BAD_COPY;
            close_v = 1'b1;
          end
        end else begin
          ram_raddr = cp_src[AddrW-1:0];
          rd_addr_d = cp_src[AddrW-1:0];
          cpleft_d  = cp_len;
          state_d   = snpdec_pkg::S_COPYRUN;
        end
      end
      snpdec_pkg::S_COPYRUN: begin
        if (out_free) begin
          ram_we    = 1'b1;
          ram_wdata = hist_byte;
          emit_v    = 1'b1;
          emit_b    = hist_byte;
          count_d   = count_q + 1'b1;
          cpleft_d  = cpleft_q - 1'b1;
          if (cpleft_q == LenW'(1)) begin
            state_d = snpdec_pkg::S_TAG;
            close_v = last_q;
          end else begin
            ram_raddr = rd_addr_q + 1'b1;
            rd_addr_d = rd_addr_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (close_v) begin
      close_st = end_status(drop_d, err_d, state_d, count_d, decl_d);
      state_d  = snpdec_pkg::S_VARINT;
      drop_d   = 1'b0;
      err_d    = snpdec_pkg::ST_OK;
      vval_d   = '0;
      vbig_d   = 1'b0;
      vidx_d   = '0;
      decl_d   = '0;
      count_d  = '0;
      last_d   = 1'b0;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit_v || close_v) begin
      out_valid_d     = 1'b1;
      out_d.out_byte  = emit_v ? emit_b : 8'd0;
      out_d.has_byte  = emit_v;
      out_d.frame_end = close_v;
      out_d.status    = close_v ? close_st : snpdec_pkg::ST_OK;
    end

    fwd_d = ram_we && (ram_waddr == ram_raddr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= snpdec_pkg::S_VARINT;
      err_q       <= snpdec_pkg::ST_OK;
      drop_q      <= 1'b0;
      vval_q      <= '0;
      vbig_q      <= 1'b0;
      vidx_q      <= '0;
      decl_q      <= '0;
      count_q     <= '0;
      lim_q       <= LimRst;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      drop_q      <= drop_d;
      vval_q      <= vval_d;
      vbig_q      <= vbig_d;
      vidx_q      <= vidx_d;
      decl_q      <= decl_d;
      count_q     <= count_d;
      lim_q       <= lim_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    info_q     <= info_d;
    xleft_q    <= xleft_d;
    xidx_q     <= xidx_d;
    extra_q    <= extra_d;
    litleft_q  <= litleft_d;
    rd_addr_q  <= rd_addr_d;
    cpleft_q   <= cpleft_d;
    out_q      <= out_d;
    fwd_data_q <= ram_wdata;
  end

endmodule

/* design/snpdec_checker.sv */
// Port-level checks for the raw block decompressor, bound to its top level.
// Depends on snpdec_pkg.
module snpdec_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input snpdec_pkg::in_t              in_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input snpdec_pkg::out_t             out_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [snpdec_pkg::CFG_W-1:0] cfg_data_i
);

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("output result changed while stalled");

  // A result without a byte only ever closes a frame, and carries a zero byte.
  a_empty_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.has_byte |-> out_o.frame_end && (out_o.out_byte == 8'd0))
    else $error("byte-less result that does not close a frame");

  // Status is reported on the closing result only.
  a_status_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.frame_end |-> out_o.status == snpdec_pkg::ST_OK)
    else $error("status outside the closing result");

  // No new request is taken while the output register is blocked.
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken with a stalled output");

endmodule

bind snappy_raw_block_decompressor_core snpdec_checker u_snpdec_checker (.*);
